>>> design/bpve_pkg.sv
`default_nettype none
package bpve_pkg;

   localparam int BPVE_PIX_W  = 10;
   localparam int BPVE_HALF_W = 9;
   localparam int BPVE_CTR_W  = 11;
   localparam int BPVE_DX_W   = 12;
   localparam int BPVE_SQ_W   = 20;
   localparam int BPVE_SQRT_IN_W = 52;
   localparam int BPVE_RQ_W   = 26;
   localparam int BPVE_INV_W  = 33;
   localparam int BPVE_Q_W    = 33;
   localparam int BPVE_PER_W  = 16;
   localparam int BPVE_OUT_W  = 32;

   localparam int IMAGE_ROWS_DEFAULT = 120;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // focal length in tenths of mm times 100, and target size in mm times 1000
   localparam int LAT_SCALE   = 30400;
   localparam int LAT_SCALE_W = 15;
   localparam int AXIAL_SCALE = 100000;
   localparam int INV_NUM_SHIFT = 48;

   localparam logic [BPVE_PER_W-1:0] PERIOD_RESET = 16'd2000;

   function automatic logic [BPVE_OUT_W-1:0] sat_apply(input logic neg,
                                                        input logic [BPVE_Q_W-1:0] q);
      logic [BPVE_OUT_W-1:0] r;
      if (!neg) begin
         r = (q > BPVE_Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[BPVE_OUT_W-1:0];
      end else begin
         r = (q > BPVE_Q_W'(32'h8000_0000)) ? 32'h8000_0000
                                             : (~q[BPVE_OUT_W-1:0]) + 32'd1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/box_pair_velocity_estimate.sv
// Throughput: one transaction per cycle; busy is never raised.
// The pipeline runs through the 27-stage square root, then the 34-stage inverse and final dividers.
// Reset: synchronous, clears every pipeline valid bit and loads the period with 2000 us.
// The receiver cannot stall: each result strobes for exactly one cycle.
`default_nettype none
module box_pair_velocity_estimate
   import bpve_pkg::*;
#(
   parameter int IMAGE_ROWS = IMAGE_ROWS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [BPVE_PIX_W-1:0]  req_prev_left,
   input  wire logic [BPVE_PIX_W-1:0]  req_prev_top,
   input  wire logic [BPVE_PIX_W-1:0]  req_prev_width,
   input  wire logic [BPVE_PIX_W-1:0]  req_prev_height,
   input  wire logic [BPVE_PIX_W-1:0]  req_cur_left,
   input  wire logic [BPVE_PIX_W-1:0]  req_cur_top,
   input  wire logic [BPVE_PIX_W-1:0]  req_cur_width,
   input  wire logic [BPVE_PIX_W-1:0]  req_cur_height,
   output logic                        rsp_strobe,
   output logic signed [BPVE_OUT_W-1:0] rsp_vel_x,
   output logic signed [BPVE_OUT_W-1:0] rsp_vel_y,
   output logic signed [BPVE_OUT_W-1:0] rsp_vel_z,
   output logic                        rsp_radius_invalid,
   input  wire logic                   csr_we,
   input  wire logic [BPVE_PER_W-1:0]  csr_wdata
);

   localparam int ROW_W   = $clog2(IMAGE_ROWS + 1);
   localparam int LMUL_W  = BPVE_DX_W + LAT_SCALE_W;
   localparam int LNUM_W  = LMUL_W + FRAC_BITS + 1;
   localparam int LDEN_W  = ROW_W + BPVE_PER_W;
   localparam longint AXK = longint'(AXIAL_SCALE) * longint'(IMAGE_ROWS);
   localparam int AXK_W   = $clog2(AXK + 1);
   localparam int ZNUM_W  = BPVE_INV_W + AXK_W + 1;
   localparam int ZDEN_W  = BPVE_PER_W + 32 - FRAC_BITS;
   localparam int SIDE0_W = 1 + 2*BPVE_DX_W;

   logic [BPVE_PER_W-1:0] period_ff;
   logic [BPVE_PER_W-1:0] period;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         period_ff <= csr_wdata;
      end
   end

   assign period = (period_ff == '0) ? BPVE_PER_W'(1) : period_ff;
   assign busy   = 1'b0;

   // stage 1: centres, shifts, squared half sizes
   logic [BPVE_HALF_W-1:0] pa, pb, ca, cb;
   logic [BPVE_CTR_W-1:0]  pcx, pcy, ccx, ccy;
   logic                   s1_valid_ff;
   logic [BPVE_DX_W-1:0]   s1_dx_ff, s1_dy_ff;
   logic                   s1_zero_ff;
   logic [BPVE_SQ_W-1:0]   s1_sq0_ff, s1_sq1_ff;

   assign pa  = req_prev_width[BPVE_PIX_W-1:1];
   assign pb  = req_prev_height[BPVE_PIX_W-1:1];
   assign ca  = req_cur_width[BPVE_PIX_W-1:1];
   assign cb  = req_cur_height[BPVE_PIX_W-1:1];
   assign pcx = BPVE_CTR_W'(req_prev_left) + BPVE_CTR_W'(pa);
   assign pcy = BPVE_CTR_W'(req_prev_top)  + BPVE_CTR_W'(pb);
   assign ccx = BPVE_CTR_W'(req_cur_left)  + BPVE_CTR_W'(ca);
   assign ccy = BPVE_CTR_W'(req_cur_top)   + BPVE_CTR_W'(cb);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_dx_ff   <= BPVE_DX_W'(ccx) - BPVE_DX_W'(pcx);
      s1_dy_ff   <= BPVE_DX_W'(ccy) - BPVE_DX_W'(pcy);
      s1_zero_ff <= (pa == '0 && pb == '0) || (ca == '0 && cb == '0);
      s1_sq0_ff  <= BPVE_SQ_W'(pa) * BPVE_SQ_W'(pa) + BPVE_SQ_W'(pb) * BPVE_SQ_W'(pb);
      s1_sq1_ff  <= BPVE_SQ_W'(ca) * BPVE_SQ_W'(ca) + BPVE_SQ_W'(cb) * BPVE_SQ_W'(cb);
   end

   // radii in Q.16
   logic                 rt_valid;
   logic [BPVE_RQ_W-1:0] rq0, rq1;
   logic [SIDE0_W-1:0]   rt_side;

   bpve_sqrt #(.IN_W(BPVE_SQRT_IN_W), .SIDE_W(SIDE0_W)) u_sqrt0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_value  ({s1_sq0_ff, 32'd0}),
      .in_side   ({s1_zero_ff, s1_dy_ff, s1_dx_ff}),
      .out_valid (rt_valid),
      .out_root  (rq0),
      .out_side  (rt_side)
   );

   bpve_sqrt #(.IN_W(BPVE_SQRT_IN_W), .SIDE_W(1)) u_sqrt1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_value  ({s1_sq1_ff, 32'd0}),
      .in_side   (1'b0),
      .out_valid (),
      .out_root  (rq1),
      .out_side  ()
   );

   // inverse radii in Q1.32
   localparam int INV_NUM_W = INV_NUM_SHIFT + 1;
   logic                  iv_valid;
   logic [BPVE_INV_W-1:0] inv0, inv1;
   logic [SIDE0_W-1:0]    iv_side;

   bpve_div #(.NUM_W(INV_NUM_W), .DEN_W(BPVE_RQ_W), .Q_W(BPVE_INV_W),
              .SIDE_W(SIDE0_W)) u_inv0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_num    (INV_NUM_W'(1) << INV_NUM_SHIFT),
      .in_den    ((rq0 == '0) ? BPVE_RQ_W'(1) : rq0),
      .in_side   (rt_side),
      .out_valid (iv_valid),
      .out_quot  (inv0),
      .out_side  (iv_side)
   );

   bpve_div #(.NUM_W(INV_NUM_W), .DEN_W(BPVE_RQ_W), .Q_W(BPVE_INV_W),
              .SIDE_W(1)) u_inv1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_num    (INV_NUM_W'(1) << INV_NUM_SHIFT),
      .in_den    ((rq1 == '0) ? BPVE_RQ_W'(1) : rq1),
      .in_side   (1'b0),
      .out_valid (),
      .out_quot  (inv1),
      .out_side  ()
   );

   // stage 3: magnitudes and signs
   logic [BPVE_DX_W-1:0]  iv_dx, iv_dy;
   logic                  iv_zero;
   logic                  s3_valid_ff, s3_zero_ff;
   logic                  s3_negx_ff, s3_negy_ff, s3_negz_ff;
   logic [BPVE_DX_W-1:0]  s3_magx_ff, s3_magy_ff;
   logic [BPVE_INV_W-1:0] s3_d_ff;

   assign {iv_zero, iv_dy, iv_dx} = iv_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= iv_valid;
      end
      s3_zero_ff <= iv_zero;
      s3_negx_ff <= iv_dx[BPVE_DX_W-1];
      s3_negy_ff <= iv_dy[BPVE_DX_W-1];
      s3_magx_ff <= iv_dx[BPVE_DX_W-1] ? (~iv_dx + BPVE_DX_W'(1)) : iv_dx;
      s3_magy_ff <= iv_dy[BPVE_DX_W-1] ? (~iv_dy + BPVE_DX_W'(1)) : iv_dy;
      s3_negz_ff <= inv0 < inv1;
      s3_d_ff    <= (inv0 < inv1) ? (inv1 - inv0) : (inv0 - inv1);
   end

   // stage 4: products
   logic              s4_valid_ff, s4_zero_ff;
   logic              s4_negx_ff, s4_negy_ff, s4_negz_ff;
   logic [LMUL_W-1:0] s4_numx_ff, s4_numy_ff;
   logic [ZNUM_W-1:0] s4_numz_ff;
   logic [LDEN_W-1:0] s4_denl_ff;
   logic [ZDEN_W-1:0] s4_denz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_zero_ff <= s3_zero_ff;
      s4_negx_ff <= s3_negx_ff;
      s4_negy_ff <= s3_negy_ff;
      s4_negz_ff <= s3_negz_ff;
      s4_numx_ff <= LMUL_W'(s3_magx_ff) * LMUL_W'(LAT_SCALE);
      s4_numy_ff <= LMUL_W'(s3_magy_ff) * LMUL_W'(LAT_SCALE);
      s4_numz_ff <= ZNUM_W'(s3_d_ff) * ZNUM_W'(AXK);
      s4_denl_ff <= LDEN_W'(IMAGE_ROWS) * LDEN_W'(period);
      s4_denz_ff <= ZDEN_W'(period) << (32 - FRAC_BITS);
   end

   // stage 5: add half divisor for round to nearest
   logic              s5_valid_ff, s5_zero_ff;
   logic              s5_negx_ff, s5_negy_ff, s5_negz_ff;
   logic [LNUM_W-1:0] s5_numx_ff, s5_numy_ff;
   logic [ZNUM_W-1:0] s5_numz_ff;
   logic [LDEN_W-1:0] s5_denl_ff;
   logic [ZDEN_W-1:0] s5_denz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_zero_ff <= s4_zero_ff;
      s5_negx_ff <= s4_negx_ff;
      s5_negy_ff <= s4_negy_ff;
      s5_negz_ff <= s4_negz_ff;
      s5_numx_ff <= (LNUM_W'(s4_numx_ff) << FRAC_BITS) + LNUM_W'(s4_denl_ff >> 1);
      s5_numy_ff <= (LNUM_W'(s4_numy_ff) << FRAC_BITS) + LNUM_W'(s4_denl_ff >> 1);
      s5_numz_ff <= s4_numz_ff + ZNUM_W'(s4_denz_ff >> 1);
      s5_denl_ff <= s4_denl_ff;
      s5_denz_ff <= s4_denz_ff;
   end

   logic                qv_valid;
   logic [BPVE_Q_W-1:0] qx, qy, qz;
   logic                qx_neg, qy_neg;
   logic [1:0]          qz_side;

   bpve_div #(.NUM_W(LNUM_W), .DEN_W(LDEN_W), .Q_W(BPVE_Q_W), .SIDE_W(1)) u_divx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_numx_ff),
      .in_den    (s5_denl_ff),
      .in_side   (s5_negx_ff),
      .out_valid (qv_valid),
      .out_quot  (qx),
      .out_side  (qx_neg)
   );

   bpve_div #(.NUM_W(LNUM_W), .DEN_W(LDEN_W), .Q_W(BPVE_Q_W), .SIDE_W(1)) u_divy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_numy_ff),
      .in_den    (s5_denl_ff),
      .in_side   (s5_negy_ff),
      .out_valid (),
      .out_quot  (qy),
      .out_side  (qy_neg)
   );

   bpve_div #(.NUM_W(ZNUM_W), .DEN_W(ZDEN_W), .Q_W(BPVE_Q_W), .SIDE_W(2)) u_divz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s5_valid_ff),
      .in_num    (s5_numz_ff),
      .in_den    (s5_denz_ff),
      .in_side   ({s5_zero_ff, s5_negz_ff}),
      .out_valid (),
      .out_quot  (qz),
      .out_side  (qz_side)
   );

   // output register: sign and saturation
   logic rsp_strobe_ff;
   logic [BPVE_OUT_W-1:0] vel_x_ff, vel_y_ff, vel_z_ff;
   logic                  invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= qv_valid;
      end
      vel_x_ff   <= sat_apply(qx_neg, qx);
      vel_y_ff   <= sat_apply(qy_neg, qy);
      vel_z_ff   <= qz_side[1] ? '0 : sat_apply(qz_side[0], qz);
      invalid_ff <= qz_side[1];
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_vel_x          = vel_x_ff;
   assign rsp_vel_y          = vel_y_ff;
   assign rsp_vel_z          = vel_z_ff;
   assign rsp_radius_invalid = invalid_ff;

endmodule
`default_nettype wire

>>> design/bpve_sqrt.sv
`default_nettype none
module bpve_sqrt
   import bpve_pkg::*;
#(
   parameter int IN_W   = BPVE_SQRT_IN_W,
   parameter int SIDE_W = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [IN_W-1:0]     in_value,
   input  wire logic [SIDE_W-1:0]   in_side,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int OUT_W = IN_W / 2;

   logic              valid_ff [0:OUT_W];
   logic [IN_W:0]     rem_ff   [0:OUT_W];
   logic [IN_W:0]     res_ff   [0:OUT_W];
   logic [SIDE_W-1:0] side_ff  [0:OUT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= (IN_W+1)'(in_value);
      res_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (IN_W - 2 - 2*k);
      logic [IN_W:0] trial;
      logic [IN_W:0] rem_in;
      logic [IN_W:0] res_in;

      always_comb begin
         trial = res_ff[k] + BIT;
         if (rem_ff[k] >= trial) begin
            rem_in = rem_ff[k] - trial;
            res_in = (res_ff[k] >> 1) + BIT;
         end else begin
            rem_in = rem_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         res_ff[k+1]  <= res_in;
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[OUT_W];
   assign out_root  = res_ff[OUT_W][OUT_W-1:0];
   assign out_side  = side_ff[OUT_W];

endmodule
`default_nettype wire

>>> design/bpve_div.sv
`default_nettype none
module bpve_div
   import bpve_pkg::*;
#(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 32,
   parameter int Q_W    = BPVE_Q_W,
   parameter int SIDE_W = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic [Q_W-1:0]          out_quot,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

   logic              valid_ff [0:Q_W];
   logic [W-1:0]      rem_ff   [0:Q_W];
   logic [DEN_W-1:0]  den_ff   [0:Q_W];
   logic [Q_W-1:0]    quot_ff  [0:Q_W];
   logic              ovf_ff   [0:Q_W];
   logic [SIDE_W-1:0] side_ff  [0:Q_W];

   // quotient too wide for Q_W bits: clamp to all ones
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= W'(in_num);
      den_ff[0]  <= in_den;
      quot_ff[0] <= '0;
      ovf_ff[0]  <= W'(in_num) >= (W'(in_den) << Q_W);
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;
      logic [W-1:0]   trial;
      logic [W-1:0]   rem_in;
      logic [Q_W-1:0] quot_in;

      always_comb begin
         trial   = W'(den_ff[k]) << SH;
         rem_in  = rem_ff[k];
         quot_in = quot_ff[k];
         if (rem_ff[k] >= trial) begin
            rem_in      = rem_ff[k] - trial;
            quot_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         den_ff[k+1]  <= den_ff[k];
         quot_ff[k+1] <= quot_in;
         ovf_ff[k+1]  <= ovf_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_quot  = ovf_ff[Q_W] ? '1 : quot_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule
`default_nettype wire

>>> tb/sv/box_pair_velocity_estimate_test.sv
`timescale 1ns / 1ps
module box_pair_velocity_estimate_test
   import bpve_pkg::*;
();

   localparam int ROWS = 120;
   localparam int FRAC = 16;
   localparam int LATENCY = 99;

   typedef struct {
      logic [9:0] pl, pt, pw, ph, cl, ct, cw, ch;
   } box_pair_type;

   typedef struct {
      logic [31:0] vx, vy, vz;
      logic        inv;
   } velocity_type;

   class velocity_scoreboard_type;
      velocity_type pending[$];
      logic [15:0]  period;
      int           errors;

      function new();
         period = PERIOD_RESET;
         errors = 0;
      endfunction

      function logic [63:0] root64(logic [63:0] v);
         logic [63:0] r;
         logic [63:0] b;
         r = '0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [31:0] round_sat(logic neg, logic [63:0] mag, logic [63:0] den);
         logic [63:0] q;
         q = (mag + den / 2) / den;
         if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(64'd0 - q);
      endfunction

      function logic [31:0] lateral_vel(longint shift, logic [63:0] per);
         logic [63:0] m;
         m = (shift < 0) ? -shift : shift;
         return round_sat(shift < 0, (m * 64'd30400) << FRAC, ROWS * per);
      endfunction

      function logic [63:0] inv_radius(logic [63:0] a, logic [63:0] b);
         return (64'd1 << 48) / root64((a * a + b * b) << 32);
      endfunction

      function void note_input(box_pair_type t);
         velocity_type e;
         logic [63:0]  per, pa, pb, ca, cb, i0, i1, d;
         longint       dx, dy;
         per = (period != 0) ? 64'(period) : 64'd1;
         pa = t.pw >> 1; pb = t.ph >> 1; ca = t.cw >> 1; cb = t.ch >> 1;
         dx = longint'(t.cl + ca) - longint'(t.pl + pa);
         dy = longint'(t.ct + cb) - longint'(t.pt + pb);
         e.vx = lateral_vel(dx, per);
         e.vy = lateral_vel(dy, per);
         if ((pa == 0 && pb == 0) || (ca == 0 && cb == 0)) begin
            e.vz = '0;
            e.inv = 1'b1;
         end else begin
            i0 = inv_radius(pa, pb);
            i1 = inv_radius(ca, cb);
            d = (i0 < i1) ? i1 - i0 : i0 - i1;
            e.vz = round_sat(i0 < i1, d * 64'd100000 * ROWS, per << (32 - FRAC));
            e.inv = 1'b0;
         end
         pending.push_back(e);
      endfunction

      function void check_result(velocity_type a);
         velocity_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result vx=%h", $time, a.vx);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.vx !== e.vx) begin
            $display("%0t: vel_x exp %h act %h", $time, e.vx, a.vx); errors++;
         end
         if (a.vy !== e.vy) begin
            $display("%0t: vel_y exp %h act %h", $time, e.vy, a.vy); errors++;
         end
         if (a.vz !== e.vz) begin
            $display("%0t: vel_z exp %h act %h", $time, e.vz, a.vz); errors++;
         end
         if (a.inv !== e.inv) begin
            $display("%0t: radius_invalid exp %b act %b", $time, e.inv, a.inv); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [9:0]  pl = 0, pt = 0, pw = 0, ph = 0, cl = 0, ct = 0, cw = 0, ch = 0;
   logic        rsp_strobe, rsp_radius_invalid;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = 0;
   logic        quiet = 0;

   velocity_scoreboard_type sb;

   always #5 clock = ~clock;

   box_pair_velocity_estimate u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_prev_left(pl), .req_prev_top(pt), .req_prev_width(pw), .req_prev_height(ph),
      .req_cur_left(cl), .req_cur_top(ct), .req_cur_width(cw), .req_cur_height(ch),
      .rsp_strobe(rsp_strobe), .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y),
      .rsp_vel_z(rsp_vel_z), .rsp_radius_invalid(rsp_radius_invalid),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      velocity_type r;
      if (!reset && rsp_strobe) begin
         r.vx = rsp_vel_x; r.vy = rsp_vel_y; r.vz = rsp_vel_z; r.inv = rsp_radius_invalid;
         sb.check_result(r);
      end
   end

   task automatic send_pair(box_pair_type t);
      start <= 1;
      pl <= t.pl; pt <= t.pt; pw <= t.pw; ph <= t.ph;
      cl <= t.cl; ct <= t.ct; cw <= t.cw; ch <= t.ch;
      do @(posedge clock); while (busy);
      sb.note_input(t);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic send_fields(int a, int b, int c, int d, int e, int f, int g, int h);
      box_pair_type t;
      t.pl = 10'(a); t.pt = 10'(b); t.pw = 10'(c); t.ph = 10'(d);
      t.cl = 10'(e); t.ct = 10'(f); t.cw = 10'(g); t.ch = 10'(h);
      send_pair(t);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_period(logic [15:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      sb.period = v;
   endtask

   function automatic logic [9:0] rand_pix();
      case ($urandom_range(0, 5))
         0: return 10'($urandom_range(0, 3));
         1: return 10'($urandom_range(1020, 1023));
         2: return 10'($urandom_range(0, 40));
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic random_phase(int n);
      box_pair_type t;
      for (int i = 0; i < n; i++) begin
         t.pl = rand_pix(); t.pt = rand_pix(); t.pw = rand_pix(); t.ph = rand_pix();
         if ($urandom_range(0, 2) == 0) begin
            // later box close to the earlier one
            t.cl = t.pl + 10'($urandom_range(0, 8)) - 10'd4;
            t.ct = t.pt + 10'($urandom_range(0, 8)) - 10'd4;
            t.cw = t.pw + 10'($urandom_range(0, 8)) - 10'd4;
            t.ch = t.ph + 10'($urandom_range(0, 8)) - 10'd4;
         end else begin
            t.cl = rand_pix(); t.ct = rand_pix(); t.cw = rand_pix(); t.ch = rand_pix();
         end
         send_pair(t);
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_fields(0, 0, 0, 0, 0, 0, 0, 0);
      send_fields(1023, 1023, 1023, 1023, 0, 0, 0, 0);
      send_fields(0, 0, 0, 0, 1023, 1023, 1023, 1023);
      send_fields(0, 0, 1023, 1023, 1023, 1023, 1023, 1023);
      send_fields(1023, 1023, 1023, 1023, 0, 0, 1023, 1023);
      send_fields(5, 5, 1, 1, 5, 5, 2, 2);
      send_fields(5, 5, 2, 2, 5, 5, 1, 1);
      send_fields(10, 10, 2, 0, 20, 20, 0, 2);
      send_fields(10, 10, 2, 2, 10, 10, 1023, 1023);
      send_fields(500, 500, 1023, 1023, 500, 500, 2, 2);
      send_fields(100, 200, 40, 30, 100, 200, 40, 30);
      send_fields(682, 341, 682, 341, 341, 682, 341, 682);
      drain();
      write_period(16'd1);
      send_fields(0, 0, 1023, 1023, 1023, 1023, 2, 2);
      send_fields(1023, 1023, 2, 2, 0, 0, 1023, 1023);
      send_fields(0, 0, 2, 2, 1, 0, 2, 2);
      drain();
      write_period(16'd0);
      send_fields(0, 0, 3, 3, 1023, 0, 1023, 3);
      send_fields(300, 300, 2, 2, 300, 300, 4, 4);
      drain();
      write_period(16'hFFFF);
      send_fields(0, 0, 1023, 1023, 1023, 1023, 2, 2);
      send_fields(1023, 1023, 0, 0, 0, 0, 0, 0);
      random_phase(200);
      drain();
      write_period(16'd2000);
      random_phase(250);
      drain();
      write_period(16'($urandom_range(1, 200)));
      random_phase(200);
      drain();
      write_period(16'($urandom));
      random_phase(100);
      quiet = 1;
      random_phase(180);
      drain();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
design/bpve_pkg.sv
design/bpve_sqrt.sv
design/bpve_div.sv
design/box_pair_velocity_estimate.sv
tb/sv/box_pair_velocity_estimate_test.sv
